// ===== sv/gmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid maximum path sum: shared package
// Field widths, register indexes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gmp_pkg;

  localparam int CELL_W     = 11;
  localparam int TOTAL_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int CELL_MAG   = 1024;
  localparam int OBSTACLE   = -1;
  localparam int TOTAL_MAX  = 32767;
  localparam int TOTAL_MIN  = -32768;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 5'd16;

  localparam logic KIND_TOTAL = 1'b0;
  localparam logic KIND_MOVE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RC_INIT,
    ST_RC_RUN,
    ST_SW_RD,
    ST_SW_WR,
    ST_TOT_RD,
    ST_TOT_EMIT,
    ST_PATH_RD,
    ST_PATH_EMIT
  } gmp_state_e;

  typedef struct packed {
    logic cell_wr;
    logic load_clear;
    logic rc_init;
    logic rc_step;
    logic sw_start;
    logic sw_read;
    logic sw_write;
    logic tot_read;
    logic tot_emit;
    logic path_read;
    logic path_emit;
  } gmp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic rc_done;
    logic sweep_done;
    logic single_cell;
    logic path_last;
  } gmp_status_t;

endpackage
`default_nettype wire

// ===== sv/gmp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid maximum path sum: cell channel
// Valid/ready channel that carries one grid cell per request.
// ----------------------------------------------------------------------------
interface gmp_in_if import gmp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_value;
  logic                     last_cell;

  modport source (output valid, cell_value, last_cell, input ready);
  modport sink   (input valid, cell_value, last_cell, output ready);
endinterface
`default_nettype wire

// ===== sv/gmp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid maximum path sum: result channel
// Valid/ready channel that carries the best total and the path moves.
// ----------------------------------------------------------------------------
interface gmp_out_if import gmp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      item_kind;
  logic signed [TOTAL_W-1:0] best_total;
  logic                      move_south;
  logic                      last_result;

  modport source (output valid, item_kind, best_total, move_south, last_result,
                  input ready);
  modport sink   (input valid, item_kind, best_total, move_south, last_result,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/gmp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid maximum path sum: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module gmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     a_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] a_addr_i,
  output logic      [WIDTH-1:0]         a_data_o,
  input  wire logic                     b_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] b_addr_i,
  output logic      [WIDTH-1:0]         b_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (a_en_i) begin
      a_data_o <= mem_q[a_addr_i];
    end
    if (b_en_i) begin
      b_data_o <= mem_q[b_addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/gmp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid maximum path sum: controller
// Sequences the load, the sweep from the bottom-right corner, the total and
// the path walk, and reindexes the load position after a register write.
// ----------------------------------------------------------------------------
module gmp_ctrl import gmp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_last_i,
  input  wire logic        cfg_we_i,
  input  wire gmp_status_t status_i,
  output logic             in_ready_o,
  output gmp_cmd_t         cmd_o
);

  gmp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = ST_SW_RD;
        end else if (cfg_we_i) begin
          state_d = ST_RC_INIT;
        end
      end
      ST_RC_INIT: begin
        state_d = cfg_we_i ? ST_RC_INIT : ST_RC_RUN;
      end
      ST_RC_RUN: begin
        if (cfg_we_i) begin
          state_d = ST_RC_INIT;
        end else if (status_i.rc_done) begin
          state_d = ST_LOAD;
        end
      end
      ST_SW_RD: begin
        state_d = ST_SW_WR;
      end
      ST_SW_WR: begin
        state_d = status_i.sweep_done ? ST_TOT_RD : ST_SW_RD;
      end
      ST_TOT_RD: begin
        state_d = ST_TOT_EMIT;
      end
      ST_TOT_EMIT: begin
        if (status_i.slot_free) begin
          state_d = status_i.single_cell ? ST_LOAD : ST_PATH_RD;
        end
      end
      ST_PATH_RD: begin
        state_d = ST_PATH_EMIT;
      end
      ST_PATH_EMIT: begin
        if (status_i.slot_free) begin
          state_d = status_i.path_last ? ST_LOAD : ST_PATH_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o     = 1'b1;
        cmd_o.cell_wr  = in_valid_i;
        cmd_o.sw_start = in_valid_i && in_last_i;
      end
      ST_RC_INIT: begin
        cmd_o.rc_init = 1'b1;
      end
      ST_RC_RUN: begin
        cmd_o.rc_step = 1'b1;
      end
      ST_SW_RD: begin
        cmd_o.sw_read = 1'b1;
      end
      ST_SW_WR: begin
        cmd_o.sw_write = 1'b1;
      end
      ST_TOT_RD: begin
        cmd_o.tot_read = 1'b1;
      end
      ST_TOT_EMIT: begin
        cmd_o.tot_emit   = status_i.slot_free;
        cmd_o.load_clear = status_i.slot_free && status_i.single_cell;
      end
      ST_PATH_RD: begin
        cmd_o.path_read = 1'b1;
      end
      ST_PATH_EMIT: begin
        cmd_o.path_emit  = status_i.slot_free;
        cmd_o.load_clear = status_i.slot_free && status_i.path_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // A last cell always starts the sweep on the following cycle.
  a_last_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && in_valid_i && in_last_i) |=> state_q == ST_SW_RD)
    else $error("last cell did not start the sweep");

  // Memory reads and result loads never overlap.
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.sw_read, cmd_o.sw_write, cmd_o.tot_read, cmd_o.tot_emit,
              cmd_o.path_read, cmd_o.path_emit}))
    else $error("controller issued overlapping commands");

endmodule
`default_nettype wire

// ===== sv/gmp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid maximum path sum: datapath
// Register file, load counters, the sweep adder and compare, the path walker,
// the grid store and the result register.
// ----------------------------------------------------------------------------
module gmp_datapath import gmp_pkg::*; #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic signed [CELL_W-1:0]     cell_value_i,
  input  wire gmp_cmd_t                     cmd_i,
  output gmp_status_t                       status_o,
  input  wire logic                         result_ready_i,
  output logic                              result_valid_o,
  output logic                              item_kind_o,
  output logic signed      [TOTAL_W-1:0]    best_total_o,
  output logic                              move_south_o,
  output logic                              last_result_o
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW1   = $clog2(MAX_ROWS + 1);
  localparam int CW1   = $clog2(MAX_COLS + 1);
  localparam int PW    = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int NW    = RW1 + CW1;
  localparam int AW    = ROW_W + COL_W;
  localparam int DEPTH = 2 ** AW;
  localparam int SUM_W = $clog2(CELL_MAG * (MAX_ROWS + MAX_COLS - 1)) + 1;
  localparam int EXT_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W;

  // Configuration registers and their clamped values.
  logic [CFG_DATA_W-1:0] rows_reg_q, cols_reg_q;
  logic [RW1-1:0]        rows_c;
  logic [CW1-1:0]        cols_c;
  logic [ROW_W-1:0]      rows_m1;
  logic [COL_W-1:0]      cols_m1;
  logic [NW-1:0]         cells_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_reg_q <= DIM_RESET;
      cols_reg_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GRID_ROWS: rows_reg_q <= cfg_data_i;
        REG_GRID_COLS: cols_reg_q <= cfg_data_i;
        default:       rows_reg_q <= rows_reg_q;
      endcase
    end
  end

  always_comb begin
    if (rows_reg_q == '0) begin
      rows_c = RW1'(1);
    end else if (32'(rows_reg_q) > 32'(MAX_ROWS)) begin
      rows_c = RW1'(MAX_ROWS);
    end else begin
      rows_c = RW1'(rows_reg_q);
    end
    if (cols_reg_q == '0) begin
      cols_c = CW1'(1);
    end else if (32'(cols_reg_q) > 32'(MAX_COLS)) begin
      cols_c = CW1'(MAX_COLS);
    end else begin
      cols_c = CW1'(cols_reg_q);
    end
  end

  assign rows_m1 = ROW_W'(rows_c - RW1'(1));
  assign cols_m1 = COL_W'(cols_c - CW1'(1));
  assign cells_n = NW'(rows_c) * NW'(cols_c);

  // Load position, kept both as a linear count and as row and column.
  // After a register write the row and column are rebuilt from the count by
  // repeated subtraction of the column count.
  logic [PW-1:0]    pos_q, rem_q;
  logic [RW1-1:0]   lr_q;
  logic [COL_W-1:0] lc_q;
  logic             room;
  logic             rc_done;

  assign room    = NW'(pos_q) < cells_n;
  assign rc_done = !((rem_q >= PW'(cols_c)) && (lr_q < RW1'(MAX_ROWS)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      rem_q <= '0;
      lr_q  <= '0;
      lc_q  <= '0;
    end else if (cmd_i.load_clear) begin
      pos_q <= '0;
      rem_q <= '0;
      lr_q  <= '0;
      lc_q  <= '0;
    end else if (cmd_i.cell_wr && room) begin
      pos_q <= pos_q + PW'(1);
      if (lc_q == cols_m1) begin
        lc_q <= '0;
        lr_q <= lr_q + RW1'(1);
      end else begin
        lc_q <= lc_q + COL_W'(1);
      end
    end else if (cmd_i.rc_init) begin
      rem_q <= pos_q;
      lr_q  <= '0;
    end else if (cmd_i.rc_step) begin
      if (!rc_done) begin
        rem_q <= rem_q - PW'(cols_c);
        lr_q  <= lr_q + RW1'(1);
      end else begin
        lc_q <= rem_q[COL_W-1:0];
      end
    end
  end

  // Sweep and path counters.
  logic [ROW_W-1:0] sr_q, pr_q, sr_p1, pr_p1, pr_next;
  logic [COL_W-1:0] sc_q, pc_q, pc_p1, pc_next;

  assign sr_p1 = sr_q + ROW_W'(1);
  assign pr_p1 = pr_q + ROW_W'(1);
  assign pc_p1 = pc_q + COL_W'(1);

  // Grid store.
  logic             ram_we, a_en, b_en;
  logic [AW-1:0]    waddr, a_addr, b_addr;
  logic [SUM_W-1:0] wdata, a_data, b_data;

  gmp_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .a_en_i   (a_en),
    .a_addr_i (a_addr),
    .a_data_o (a_data),
    .b_en_i   (b_en),
    .b_addr_i (b_addr),
    .b_data_o (b_data)
  );

  logic signed [SUM_W-1:0] a_s, b_s, v_s, e_s, s_s, best_s, sum_new;
  logic signed [SUM_W-1:0] e_q;
  logic                    obstacle;

  assign a_s = $signed(a_data);
  assign b_s = $signed(b_data);

  // Sweep step: the east neighbour is the cell just finished on this row.
  always_comb begin
    v_s      = a_s;
    s_s      = (sr_q != rows_m1) ? b_s : '0;
    e_s      = (sc_q != cols_m1) ? e_q : '0;
    best_s   = (e_s > s_s) ? e_s : s_s;
    sum_new  = v_s + best_s;
    obstacle = (v_s == SUM_W'(OBSTACLE));
  end

  assign a_en   = cmd_i.sw_read || cmd_i.tot_read || cmd_i.path_read;
  assign b_en   = cmd_i.sw_read || cmd_i.path_read;
  assign ram_we = (cmd_i.cell_wr && room) || (cmd_i.sw_write && !obstacle);
  assign waddr  = cmd_i.sw_write ? {sr_q, sc_q} : {lr_q[ROW_W-1:0], lc_q};
  assign wdata  = cmd_i.sw_write ? sum_new : SUM_W'(cell_value_i);

  always_comb begin
    if (cmd_i.sw_read) begin
      a_addr = {sr_q, sc_q};
      b_addr = {sr_p1, sc_q};
    end else if (cmd_i.path_read) begin
      a_addr = {pr_q, pc_p1};
      b_addr = {pr_p1, pc_q};
    end else begin
      a_addr = '0;
      b_addr = '0;
    end
  end

  // Path decision: east only when the east sum is strictly larger.
  logic south;

  always_comb begin
    if (pr_q == rows_m1) begin
      south = 1'b0;
    end else if (pc_q == cols_m1) begin
      south = 1'b1;
    end else begin
      south = !(a_s > b_s);
    end
    pr_next = south ? pr_p1 : pr_q;
    pc_next = south ? pc_q : pc_p1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q <= '0;
      sc_q <= '0;
      pr_q <= '0;
      pc_q <= '0;
    end else begin
      if (cmd_i.sw_start) begin
        sr_q <= rows_m1;
        sc_q <= cols_m1;
      end else if (cmd_i.sw_write) begin
        if (sc_q != '0) begin
          sc_q <= sc_q - COL_W'(1);
        end else if (sr_q != '0) begin
          sc_q <= cols_m1;
          sr_q <= sr_q - ROW_W'(1);
        end
      end
      if (cmd_i.tot_emit) begin
        pr_q <= '0;
        pc_q <= '0;
      end else if (cmd_i.path_emit) begin
        pr_q <= pr_next;
        pc_q <= pc_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sw_write) begin
      e_q <= obstacle ? v_s : sum_new;
    end
  end

  // Saturate the top-left sum to the result range.
  logic signed [EXT_W-1:0]   tot_ext;
  logic signed [TOTAL_W-1:0] tot_sat;

  always_comb begin
    tot_ext = EXT_W'(a_s);
    if (tot_ext > EXT_W'(TOTAL_MAX)) begin
      tot_sat = TOTAL_W'(TOTAL_MAX);
    end else if (tot_ext < EXT_W'(TOTAL_MIN)) begin
      tot_sat = TOTAL_W'(TOTAL_MIN);
    end else begin
      tot_sat = TOTAL_W'(tot_ext);
    end
  end

  // Result register.
  logic                      res_valid_q;
  logic                      kind_q, south_q, last_q;
  logic signed [TOTAL_W-1:0] total_q;
  logic                      single_cell, path_last, out_load;

  assign single_cell = (rows_m1 == '0) && (cols_m1 == '0);
  assign path_last   = (pr_next == rows_m1) && (pc_next == cols_m1);
  assign out_load    = cmd_i.tot_emit || cmd_i.path_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_load) begin
      res_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tot_emit) begin
      kind_q  <= KIND_TOTAL;
      total_q <= tot_sat;
      south_q <= 1'b0;
      last_q  <= single_cell;
    end else if (cmd_i.path_emit) begin
      kind_q  <= KIND_MOVE;
      total_q <= '0;
      south_q <= south;
      last_q  <= path_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign item_kind_o    = kind_q;
  assign best_total_o   = total_q;
  assign move_south_o   = south_q;
  assign last_result_o  = last_q;

  assign status_o.slot_free   = !res_valid_q || result_ready_i;
  assign status_o.rc_done     = rc_done;
  assign status_o.sweep_done  = (sr_q == '0) && (sc_q == '0);
  assign status_o.single_cell = single_cell;
  assign status_o.path_last   = path_last;

  // The walker never leaves the grid while it emits moves.
  a_path_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.path_emit |-> (pr_q <= rows_m1) && (pc_q <= cols_m1))
    else $error("path walker outside the grid");

  // A move flagged as last leaves the walker on the bottom-right corner.
  a_last_move_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.path_emit && path_last) |=> (pr_q == rows_m1) && (pc_q == cols_m1))
    else $error("last move does not end on the corner");

  // A result is loaded only when the previous one has gone or is leaving.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!res_valid_q || result_ready_i))
    else $error("result register overwritten");

endmodule
`default_nettype wire

// ===== sv/grid_max_path_sum_dp_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: cells are taken one per cycle while the controller is in its load
// state; after the last cell the sweep does one store read and one write per grid
// cell, then the total is read and emitted. Each path move is a two-port store
// read, then the compare, and waits while the result register is held. After the
// last register write the cell channel stalls while the load row and column are
// rebuilt. Reset clears the control state and sets both dims to 16.
// ----------------------------------------------------------------------------
// Grid maximum path sum: top level
// Loads a grid, sweeps it for the best right/down path sum and emits the
// total followed by the moves of the path.
// ----------------------------------------------------------------------------
module grid_max_path_sum_dp_unit import gmp_pkg::*; #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  gmp_in_if.sink                     cell_i,
  gmp_out_if.source                  result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  gmp_cmd_t    cmd;
  gmp_status_t status;
  logic        in_ready;

  gmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cell_i.valid),
    .in_last_i  (cell_i.last_cell),
    .cfg_we_i   (cfg_we_i),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  gmp_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cell_value_i   (cell_i.cell_value),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_ready_i (result_o.ready),
    .result_valid_o (result_o.valid),
    .item_kind_o    (result_o.item_kind),
    .best_total_o   (result_o.best_total),
    .move_south_o   (result_o.move_south),
    .last_result_o  (result_o.last_result)
  );

  assign cell_i.ready = in_ready;

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid maximum path sum: testbench
// Loads grids through the cell channel under random sender bursts and
// receiver stalls. A scoreboard sweeps its own copy of every grid and checks
// the best total and each path move against the results in order.
// ----------------------------------------------------------------------------
module tb_top;
  import gmp_pkg::*;

  localparam int GRID_MAX       = 16;
  localparam int RANDOM_CELLS   = 64;
  localparam int RANDOM_RESULTS = 48;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 64;
  localparam longint LIMIT_NS   = 64'd10_000_000;

  typedef logic signed [CELL_W-1:0]  cell_t;
  typedef logic signed [TOTAL_W-1:0] total_t;
  typedef logic [CFG_DATA_W-1:0]     dim_t;

  typedef enum int {
    FILL_WIDE,
    FILL_TIES,
    FILL_OBSTACLES,
    FILL_HIGH
  } fill_style_e;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PULSED
  } rx_mode_e;

  typedef struct {
    logic   kind;
    total_t total;
    logic   south;
    logic   last;
  } path_result_t;

  class path_scoreboard;
    int           grid[GRID_MAX][GRID_MAX];
    int           load_pos;
    dim_t         rows_reg;
    dim_t         cols_reg;
    path_result_t expected_q[$];
    int           mismatches;
    int           cells_taken;
    int           results_seen;

    function new();
      load_pos     = 0;
      rows_reg     = DIM_RESET;
      cols_reg     = DIM_RESET;
      mismatches   = 0;
      cells_taken  = 0;
      results_seen = 0;
    endfunction

    static function int clamp_dim(dim_t v);
      if (v == 0) return 1;
      if (v > GRID_MAX) return GRID_MAX;
      return int'(v);
    endfunction

    function int active_rows();
      return clamp_dim(rows_reg);
    endfunction

    function int active_cols();
      return clamp_dim(cols_reg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(cfg_reg_e idx, dim_t data);
      if (idx == REG_GRID_ROWS) rows_reg = data;
      else cols_reg = data;
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Takes one accepted cell request; the flagged cell sweeps the grid and
    // queues the total followed by the moves of the path.
    function void note_cell(cell_t value, logic last);
      int           rows;
      int           cols;
      int           east;
      int           south_sum;
      int           tot;
      int           pr;
      int           pc;
      logic         south;
      path_result_t res;
      rows = active_rows();
      cols = active_cols();
      if (load_pos < rows * cols) begin
        grid[load_pos / cols][load_pos % cols] = int'(value);
        load_pos++;
        cells_taken++;
      end else if (last) begin
        cells_taken++;
      end
      if (!last) return;

      for (int r = rows - 1; r >= 0; r--) begin
        for (int c = cols - 1; c >= 0; c--) begin
          if (grid[r][c] != OBSTACLE) begin
            east      = (c + 1 < cols) ? grid[r][c + 1] : 0;
            south_sum = (r + 1 < rows) ? grid[r + 1][c] : 0;
            grid[r][c] = grid[r][c] + ((east > south_sum) ? east : south_sum);
          end
        end
      end

      tot = grid[0][0];
      if (tot > TOTAL_MAX) tot = TOTAL_MAX;
      if (tot < TOTAL_MIN) tot = TOTAL_MIN;
      res.kind  = KIND_TOTAL;
      res.total = total_t'(tot);
      res.south = 1'b0;
      res.last  = (rows == 1 && cols == 1);
      expected_q.push_back(res);

      // Ties go south; the last row and column run straight to the corner.
      pr = 0;
      pc = 0;
      while (pr + 1 < rows || pc + 1 < cols) begin
        if (pr + 1 >= rows) south = 1'b0;
        else if (pc + 1 >= cols) south = 1'b1;
        else south = !(grid[pr][pc + 1] > grid[pr + 1][pc]);
        if (south) pr++;
        else pc++;
        res.kind  = KIND_MOVE;
        res.total = '0;
        res.south = south;
        res.last  = (pr + 1 >= rows && pc + 1 >= cols);
        expected_q.push_back(res);
      end
      load_pos = 0;
    endfunction

    task check_result(logic kind, total_t total, logic south, logic last);
      path_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing pending: kind %b total %0d",
                                results_seen, kind, total));
      end else begin
        want = expected_q.pop_front();
        if (kind !== want.kind || total !== want.total || south !== want.south ||
            last !== want.last) begin
          flag_mismatch($sformatf(
            "result %0d: kind/total/south/last %b/%0d/%b/%b, expected %b/%0d/%b/%b",
            results_seen, kind, total, south, last,
            want.kind, want.total, want.south, want.last));
        end
      end
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  gmp_in_if  cell_if ();
  gmp_out_if result_if ();

  path_scoreboard sb = new();
  int             burst_left = 0;

  grid_max_path_sum_dp_unit #(
    .MAX_ROWS (GRID_MAX),
    .MAX_COLS (GRID_MAX)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_i     (cell_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: switches at random between stall modes.
  initial begin
    rx_mode_e mode;
    int       mode_left;
    mode      = RX_OPEN;
    mode_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
        RX_OPEN:  result_if.ready = 1'b1;
        RX_LIGHT: result_if.ready = ($urandom_range(0, 3) != 0);
        RX_HEAVY: result_if.ready = ($urandom_range(0, 3) == 0);
        default:  result_if.ready = ((mode_left % 12) < 5);
      endcase
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid === 1'b1 && result_if.ready)
        sb.check_result(result_if.item_kind, result_if.best_total,
                        result_if.move_south, result_if.last_result);
    end
  end

  // One cell request; the sender idles between bursts of random length.
  task automatic send_cell(input cell_t value, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        cell_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    cell_if.valid      = 1'b1;
    cell_if.cell_value = value;
    cell_if.last_cell  = last;
    @(posedge clk_i);
    while (!cell_if.ready) @(posedge clk_i);
    sb.note_cell(value, last);
    burst_left--;
  endtask

  task automatic send_load(input cell_t cells[$]);
    foreach (cells[i]) send_cell(cells[i], (i == cells.size() - 1));
  endtask

  // Holds the sender until every pending result has come out.
  task automatic wait_idle();
    if (cell_if.valid) begin
      @(negedge clk_i);
      cell_if.valid = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic set_dims(input dim_t rows_d, input dim_t cols_d);
    wait_idle();
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = REG_GRID_ROWS;
    cfg_data = rows_d;
    @(negedge clk_i);
    cfg_idx  = REG_GRID_COLS;
    cfg_data = cols_d;
    @(negedge clk_i);
    cfg_we   = 1'b0;
    sb.write_reg(REG_GRID_ROWS, rows_d);
    sb.write_reg(REG_GRID_COLS, cols_d);
  endtask

  function automatic cell_t pick_cell(fill_style_e style);
    case (style)
      FILL_WIDE: return cell_t'($urandom_range(0, 2047));
      FILL_TIES: begin
        if ($urandom_range(0, 3) == 0) return cell_t'(OBSTACLE);
        return cell_t'($urandom_range(0, 2));
      end
      FILL_OBSTACLES: begin
        if ($urandom_range(0, 1) == 0) return cell_t'(OBSTACLE);
        return cell_t'($urandom_range(0, 40));
      end
      default: begin
        if ($urandom_range(0, 7) == 0) return cell_t'(OBSTACLE);
        return cell_t'($urandom_range(1000, 1023));
      end
    endcase
  endfunction

  // A full load, now and then followed by surplus cells that the block drops.
  task automatic random_load();
    cell_t       cells[$];
    fill_style_e style;
    int          n;
    int          extra;
    style = fill_style_e'($urandom_range(0, 3));
    n     = sb.active_rows() * sb.active_cols();
    extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    cells.delete();
    repeat (n + extra) cells.push_back(pick_cell(style));
    send_load(cells);
  endtask

  function automatic dim_t pick_dim();
    case ($urandom_range(0, 7))
      0:       return dim_t'(0);
      1:       return dim_t'($urandom_range(17, 31));
      2:       return dim_t'(GRID_MAX);
      default: return dim_t'($urandom_range(1, 5));
    endcase
  endfunction

  initial begin
    cell_t cells[$];
    dim_t  rows_d;
    dim_t  cols_d;
    int    base_cells;
    int    base_results;
    int    loads;

    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_GRID_ROWS;
    cfg_data           = '0;
    cell_if.valid      = 1'b0;
    cell_if.cell_value = '0;
    cell_if.last_cell  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Single cell grids: largest payoff, an obstacle, most negative value.
    set_dims(dim_t'(0), dim_t'(1));
    cells = '{cell_t'(1023)};
    send_load(cells);
    cells = '{cell_t'(OBSTACLE)};
    send_load(cells);
    cells = '{cell_t'(-1024)};
    send_load(cells);

    // One row with an obstacle in the middle.
    set_dims(dim_t'(1), dim_t'(3));
    cells = '{cell_t'(5), cell_t'(OBSTACLE), cell_t'(7)};
    send_load(cells);

    // Equal cells force ties, and two surplus cells follow the load.
    set_dims(dim_t'(3), dim_t'(2));
    cells = '{cell_t'(2), cell_t'(2), cell_t'(2), cell_t'(2), cell_t'(2), cell_t'(2),
              cell_t'(9), cell_t'(9)};
    send_load(cells);

    // East strictly better, with a value below the obstacle marker.
    set_dims(dim_t'(2), dim_t'(2));
    cells = '{cell_t'(1), cell_t'(6), cell_t'(-5), cell_t'(0)};
    send_load(cells);
    cells = '{cell_t'(OBSTACLE), cell_t'(OBSTACLE), cell_t'(OBSTACLE), cell_t'(OBSTACLE)};
    send_load(cells);

    base_cells   = sb.cells_taken;
    base_results = sb.results_seen;

    // The longest column and the longest row.
    set_dims(dim_t'(GRID_MAX), dim_t'(0));
    random_load();
    set_dims(dim_t'(0), dim_t'(17));
    random_load();

    while (sb.cells_taken - base_cells < RANDOM_CELLS ||
           sb.results_seen - base_results < RANDOM_RESULTS) begin
      if ($urandom_range(0, 2) != 0) begin
        rows_d = pick_dim();
        cols_d = pick_dim();
        if (path_scoreboard::clamp_dim(rows_d) * path_scoreboard::clamp_dim(cols_d) > 24)
          cols_d = dim_t'($urandom_range(1, 3));
        set_dims(rows_d, cols_d);
      end
      loads = $urandom_range(1, 3);
      repeat (loads) begin
        if ($urandom_range(0, 3) == 0) wait_idle();
        random_load();
      end
    end

    @(negedge clk_i);
    cell_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.check_drained();
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gmp_pkg.sv
sv/gmp_in_if.sv
sv/gmp_out_if.sv
sv/gmp_ram.sv
sv/gmp_ctrl.sv
sv/gmp_datapath.sv
sv/grid_max_path_sum_dp_unit.sv
sim/tb_top.sv
